// ===== design/signed_binary_to_decimal_ascii_core_defines.svh =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core_defines
// assertion macros of the converter rtl
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SBDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbda assertion failed");

// next-cycle implication, disabled while reset is low
`define SBDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbda assertion failed");

`endif

// ===== design/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// types and constants of the signed binary to decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

    // input word and character widths
    localparam int IN_W   = 32;
    localparam int CHAR_W = 6;

    // decimal digit positions of the magnitude and the saturation limit
    localparam int MAG_DIGITS = 10;
    localparam int MAX_DIGITS = 10;

    // counter sizing
    localparam int BIT_W     = $clog2(IN_W);
    localparam int CNT_DEPTH = (MAX_DIGITS > MAG_DIGITS) ? MAX_DIGITS : MAG_DIGITS;
    localparam int IDX_W     = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
    localparam int DIG_IDX_W = $clog2(MAG_DIGITS);

    // character codes
    localparam logic [CHAR_W-1:0] CH_MINUS   = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CH_ZERO    = CHAR_W'(48);
    localparam logic [3:0]        DIGIT_NINE = 4'd9;

    // packed bcd register, one nibble per decimal digit
    typedef logic [MAG_DIGITS-1:0][3:0] t_bcd;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT,
        ST_SAT
    } t_state;

endpackage

`default_nettype wire

// ===== design/sbda_dabble_step.sv =====
// ----------------------------------------------------------------------------
// sbda_dabble_step
// one shift-add-3 step: corrects every bcd digit and shifts in one binary bit
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_dabble_step (
    input  sbda_pkg::t_bcd i_bcd,
    input  logic           i_bit,
    output sbda_pkg::t_bcd o_bcd
);

    sbda_pkg::t_bcd                    w_adj;
    logic [sbda_pkg::MAG_DIGITS*4-1:0] w_flat;

    // add 3 to every digit of 5 or more
    always_comb begin
        for (int i = 0; i < sbda_pkg::MAG_DIGITS; i++) begin
            if (i_bcd[i] >= 4'd5) begin
                w_adj[i] = i_bcd[i] + 4'd3;
            end else begin
                w_adj[i] = i_bcd[i];
            end
        end
    end

    // shift the corrected digits left, new binary bit enters at the bottom
    assign w_flat = w_adj;
    assign o_bcd  = {w_flat[sbda_pkg::MAG_DIGITS*4-2:0], i_bit};

endmodule

`default_nettype wire

// ===== design/signed_binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// renders a signed 32-bit integer as decimal ascii characters, msd first
// ----------------------------------------------------------------------------
//  channel   direction  ports                          handshake
//  number    in         i_number                       start, busy
//  character out        o_character, o_last            o_strobe
//
//  an accepted word is converted by shift-add-3 steps in the shared dabble
//  step, one per input bit, then passes the sign state and visits each
//  digit position in turn (10 digit positions, leading zeros skipped
//  without output), or emits MAX_DIGITS nines when the digits saturate.
//  busy drops in the cycle the last character is on the outputs; the next
//  word may be started then. reset is synchronous and returns to idle.
//  the receiver cannot stall: each character is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_binary_to_decimal_ascii_core_defines.svh"

module signed_binary_to_decimal_ascii_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [sbda_pkg::IN_W-1:0] i_number,
    output logic                             o_strobe,
    output logic [sbda_pkg::CHAR_W-1:0]      o_character,
    output logic                             o_last
);

    sbda_pkg::t_state                 r_state, n_state;
    logic [sbda_pkg::IN_W-1:0]        r_mag,   n_mag;
    sbda_pkg::t_bcd                   r_bcd,   n_bcd;
    logic [sbda_pkg::BIT_W-1:0]       r_bit,   n_bit;
    logic [sbda_pkg::IDX_W-1:0]       r_idx,   n_idx;
    logic                             r_neg,   n_neg;
    logic                             r_strobe, n_strobe;
    logic [sbda_pkg::CHAR_W-1:0]      r_char,  n_char;
    logic                             r_last,  n_last;

    logic [sbda_pkg::IN_W-1:0]        w_raw;
    sbda_pkg::t_bcd                   w_dab;
    logic [3:0]                       w_dig;
    logic                             w_ovf;

    assign w_raw = i_number;

    // shared shift-add-3 unit
    sbda_dabble_step u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_mag[sbda_pkg::IN_W-1]),
        .o_bcd (w_dab)
    );

    // digit under the output pointer
    assign w_dig = r_bcd[r_idx[sbda_pkg::DIG_IDX_W-1:0]];

    // magnitude needs more digits than the saturation limit
    always_comb begin
        w_ovf = 1'b0;
        for (int i = 0; i < sbda_pkg::MAG_DIGITS; i++) begin
            if ((i >= sbda_pkg::MAX_DIGITS) && (r_bcd[i] != 4'd0)) begin
                w_ovf = 1'b1;
            end
        end
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbda_pkg::ST_IDLE;
            r_bit    <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bit    <= n_bit;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    // sequencer: next state and result word
    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_bit    = r_bit;
        n_idx    = r_idx;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        unique case (r_state)
            sbda_pkg::ST_IDLE: begin
                if (start) begin
                    n_neg   = w_raw[sbda_pkg::IN_W-1];
                    n_mag   = w_raw[sbda_pkg::IN_W-1] ? (~w_raw + 1'b1) : w_raw;
                    n_bcd   = '0;
                    n_bit   = '0;
                    n_state = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV: begin
                n_bcd = w_dab;
                n_mag = {r_mag[sbda_pkg::IN_W-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (r_bit == sbda_pkg::BIT_W'(sbda_pkg::IN_W - 1)) begin
                    n_state = sbda_pkg::ST_SIGN;
                end
            end
            sbda_pkg::ST_SIGN: begin
                if (r_neg) begin
                    n_strobe = 1'b1;
                    n_char   = sbda_pkg::CH_MINUS;
                    n_last   = 1'b0;
                end
                if (w_ovf) begin
                    n_idx   = sbda_pkg::IDX_W'(sbda_pkg::MAX_DIGITS - 1);
                    n_state = sbda_pkg::ST_SAT;
                end else begin
                    n_idx   = sbda_pkg::IDX_W'(sbda_pkg::MAG_DIGITS - 1);
                    n_state = sbda_pkg::ST_SKIP;
                end
            end
            sbda_pkg::ST_SKIP: begin
                if ((w_dig == 4'd0) && (r_idx != '0)) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_strobe = 1'b1;
                    n_char   = sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(w_dig);
                    n_last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = sbda_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = sbda_pkg::ST_EMIT;
                    end
                end
            end
            sbda_pkg::ST_EMIT: begin
                n_strobe = 1'b1;
                n_char   = sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(w_dig);
                n_last   = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = sbda_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            sbda_pkg::ST_SAT: begin
                n_strobe = 1'b1;
                n_char   = sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(sbda_pkg::DIGIT_NINE);
                n_last   = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = sbda_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_state = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy        = (r_state != sbda_pkg::ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    // a character that is not the last one leaves the sequencer busy
    `SBDA_ASSERT_SAME(a_mid_run_busy, i_clk, i_rst_n, r_strobe && !r_last, busy)
    // an accepted word always starts the conversion
    `SBDA_ASSERT_NEXT(a_start_conv, i_clk, i_rst_n, start && !busy,
                      r_state == sbda_pkg::ST_CONV && r_bit == '0)
    // the minus sign never ends a run
    `SBDA_ASSERT_SAME(a_minus_not_last, i_clk, i_rst_n,
                      r_strobe && (r_char == sbda_pkg::CH_MINUS), !r_last)
    // every character is a minus sign or a decimal digit
    `SBDA_ASSERT_SAME(a_char_code, i_clk, i_rst_n, r_strobe,
                      (r_char == sbda_pkg::CH_MINUS) ||
                      ((r_char >= sbda_pkg::CH_ZERO) &&
                       (r_char <= sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(9))))

endmodule

`default_nettype wire
